// ----- src/dlt_pkg.sv -----
// shared types, codes and constants of the dhcp lease table
package dlt_pkg;

	localparam int LEASE_COUNT_DEF = 8;

	localparam int CMD_W    = 2;
	localparam int MAC_W    = 48;
	localparam int IP_W     = 32;
	localparam int TICK_W   = 32;
	localparam int STATUS_W = 2;
	localparam int PREFIX_W = 24;
	localparam int HOST_W   = 8;
	localparam int EXP_W    = 16;
	localparam int CFG_W    = PREFIX_W;
	localparam int CFG_IDX_W = 1;

	localparam logic [PREFIX_W-1:0] PREFIX_RST = 24'hC0A801;
	localparam logic [HOST_W-1:0]   BASE_RST   = 8'd16;

	localparam int LEASE_SECONDS = 24 * 60 * 60;
	localparam int MS_PER_S      = 1000;
	localparam logic [TICK_W-1:0] LEASE_MS  = TICK_W'(LEASE_SECONDS * MS_PER_S);
	localparam logic [EXP_W-1:0]  LOW_FILL  = 16'hffff;

	// message kinds
	localparam logic [CMD_W-1:0] CMD_DISCOVER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REQUEST  = 2'd1;

	// result codes
	localparam logic [STATUS_W-1:0] ST_OFFER = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ACK   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SERVER_PREFIX = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_HOST     = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_REQ_RD,
		S_REQ_CHK,
		S_EMIT
	} state_t;

	typedef enum logic {
		ALU_EXPIRY,
		ALU_LEASE
	} alu_op_t;

	typedef struct packed {
		alu_op_t           op;
		logic [EXP_W-1:0]  expiry;
		logic [TICK_W-1:0] now;
	} alu_req_t;

endpackage

// ----- src/dlt_ifs.sv -----
// request and result channels of the lease table
interface dlt_req_if import dlt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [MAC_W-1:0]  client_mac;
	logic              req_present;
	logic [IP_W-1:0]   requested_ip;
	logic [TICK_W-1:0] now_ms;

	modport source (output valid, cmd, client_mac, req_present, requested_ip, now_ms,
		input ready);
	modport sink (input valid, cmd, client_mac, req_present, requested_ip, now_ms,
		output ready);
endinterface

interface dlt_res_if import dlt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [IP_W-1:0]     assigned_ip;

	modport source (output valid, status, assigned_ip, input ready);
	modport sink (input valid, status, assigned_ip, output ready);
endinterface

// ----- src/dlt_alu.sv -----
// shared adder for the expiry test and the new lease end
module dlt_alu import dlt_pkg::*; (
	input  alu_req_t          req,
	output logic [TICK_W-1:0] sum
);

	always_comb begin
		case (req.op)
			ALU_EXPIRY: sum = {req.expiry, LOW_FILL} - req.now;
			ALU_LEASE:  sum = req.now + LEASE_MS;
			default:    sum = '0;
		endcase
	end

endmodule

// ----- src/dhcp_lease_table.sv -----
// Lease table of a small DHCP server. One item is in work at a time; ready drops after a
// transfer and returns when the item is done. A discover reads the table one entry per
// cycle through the single read port of the lease memory, and a MAC match ends the scan
// early. The result sits in an output register, so the next item is taken while it waits.
// The table is empty after reset with no clearing pass.
module dhcp_lease_table import dlt_pkg::*; #(
	parameter int LEASE_COUNT = LEASE_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dlt_req_if.sink              req,
	dlt_res_if.source            res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int IW = (LEASE_COUNT > 1) ? $clog2(LEASE_COUNT) : 1;
	localparam int CW = $clog2(LEASE_COUNT + 1);
	localparam int DW = MAC_W + EXP_W;
	localparam logic [CW-1:0]     N_C      = CW'(LEASE_COUNT);
	localparam logic [IW-1:0]     LAST_IDX = IW'(LEASE_COUNT - 1);
	localparam logic [HOST_W-1:0] N_HOST   = HOST_W'(LEASE_COUNT);

	state_t state_q, state_d;

	logic [PREFIX_W-1:0] prefix_q;
	logic [HOST_W-1:0]   base_q;

	logic [MAC_W-1:0]  mac_q;
	logic              rp_q;
	logic [IP_W-1:0]   rip_q;
	logic [TICK_W-1:0] now_q;

	logic [DW-1:0] mem [LEASE_COUNT];
	logic          vld_q [LEASE_COUNT];
	logic [DW-1:0] rdata_s1;
	logic          rvld_s1;
	logic [IW-1:0] idx_s1;
	logic          ev_s1, ev_d;

	logic [CW-1:0] cnt_q, cnt_d;
	logic          found_q, found_d;
	logic [IW-1:0] pick_q, pick_d;

	logic [STATUS_W-1:0] res_st_q, out_st_q, fin_st;
	logic [IP_W-1:0]     res_ip_q, out_ip_q;
	logic                out_vld_q;
	logic [IW-1:0]       fin_pick;
	logic                fin, rd_en, wr_en, clr_en, emit, accept;
	logic [IW-1:0]       rd_addr;

	logic [MAC_W-1:0]  own_s1;
	logic [EXP_W-1:0]  exp_s1;
	logic [HOST_W-1:0] idx8;
	logic              req_ok, expired;
	alu_req_t          alu_req;
	logic [TICK_W-1:0] alu_sum;

	assign own_s1  = rvld_s1 ? rdata_s1[DW-1:EXP_W] : '0;
	assign exp_s1  = rvld_s1 ? rdata_s1[EXP_W-1:0] : '0;
	assign idx8    = rip_q[HOST_W-1:0] - base_q;
	assign req_ok  = rp_q && (rip_q[IP_W-1:HOST_W] == prefix_q) && (idx8 < N_HOST);
	assign expired = alu_sum[TICK_W-1];
	assign accept  = req.valid && req.ready;

	assign alu_req.op     = (state_q == S_REQ_CHK) ? ALU_LEASE : ALU_EXPIRY;
	assign alu_req.expiry = exp_s1;
	assign alu_req.now    = now_q;

	dlt_alu u_alu (
		.req (alu_req),
		.sum (alu_sum)
	);

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = cnt_q[IW-1:0];
		wr_en     = 1'b0;
		clr_en    = 1'b0;
		fin       = 1'b0;
		fin_st    = ST_DROP;
		fin_pick  = pick_q;
		cnt_d     = cnt_q;
		found_d   = found_q;
		pick_d    = pick_q;
		ev_d      = 1'b0;
		emit      = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					cnt_d   = '0;
					found_d = 1'b0;
					pick_d  = '0;
					case (req.cmd)
						CMD_DISCOVER: state_d = S_SCAN;
						CMD_REQUEST:  state_d = S_REQ_RD;
						default: begin
							fin     = 1'b1;
							state_d = S_EMIT;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (ev_s1 && own_s1 == mac_q) begin
					// a match anywhere in the table wins over an earlier candidate
					fin      = 1'b1;
					fin_st   = ST_OFFER;
					fin_pick = idx_s1;
					state_d  = S_EMIT;
				end else begin
					if (ev_s1 && !found_q && (own_s1 == '0 || expired)) begin
						found_d = 1'b1;
						pick_d  = idx_s1;
					end
					clr_en = ev_s1 && !found_q && expired;
					if (ev_s1 && idx_s1 == LAST_IDX) begin
						fin      = 1'b1;
						fin_st   = found_d ? ST_OFFER : ST_DROP;
						fin_pick = pick_d;
						state_d  = S_EMIT;
					end else if (cnt_q < N_C) begin
						rd_en = 1'b1;
						ev_d  = 1'b1;
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			S_REQ_RD: begin
				if (req_ok) begin
					rd_en   = 1'b1;
					rd_addr = idx8[IW-1:0];
					state_d = S_REQ_CHK;
				end else begin
					fin     = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_REQ_CHK: begin
				fin     = 1'b1;
				state_d = S_EMIT;
				if (own_s1 == '0 || own_s1 == mac_q) begin
					wr_en    = 1'b1;
					fin_st   = ST_ACK;
					fin_pick = idx_s1;
				end
			end
			S_EMIT: begin
				if (!out_vld_q || res.ready) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ev_s1   <= 1'b0;
			cnt_q   <= '0;
			found_q <= 1'b0;
			pick_q  <= '0;
		end else begin
			state_q <= state_d;
			ev_s1   <= ev_d;
			cnt_q   <= cnt_d;
			found_q <= found_d;
			pick_q  <= pick_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= PREFIX_RST;
			base_q   <= BASE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SERVER_PREFIX: prefix_q <= cfg_wdata[PREFIX_W-1:0];
				REG_BASE_HOST:     base_q   <= cfg_wdata[HOST_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mac_q <= req.client_mac;
			rp_q  <= req.req_present;
			rip_q <= req.requested_ip;
			now_q <= req.now_ms;
		end
	end

	// lease memory: owner in the top bits, expiry below
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[idx_s1] <= {mac_q, alu_sum[TICK_W-1:TICK_W-EXP_W]};
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
			rvld_s1  <= vld_q[rd_addr];
			idx_s1   <= rd_addr;
		end
	end

	// an entry without its valid bit reads as free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEASE_COUNT; i++)
				vld_q[i] <= 1'b0;
		end else if (wr_en) begin
			vld_q[idx_s1] <= 1'b1;
		end else if (clr_en) begin
			vld_q[idx_s1] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			res_st_q <= fin_st;
			res_ip_q <= (fin_st == ST_DROP) ? '0
				: {prefix_q, HOST_W'(base_q + HOST_W'(fin_pick))};
		end
		if (emit) begin
			out_st_q <= res_st_q;
			out_ip_q <= res_ip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (emit)
			out_vld_q <= 1'b1;
		else if (res.ready)
			out_vld_q <= 1'b0;
	end

	assign res.valid       = out_vld_q;
	assign res.status      = out_st_q;
	assign res.assigned_ip = out_ip_q;

	// a claimed lease always reports an acknowledge
	ap_ack_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> res_st_q == ST_ACK)
		else $error("lease written without acknowledge");

	// one item in work at a time
	ap_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("input ready right after a transfer");

	ap_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> cnt_q <= N_C)
		else $error("scan counter past the table");

	ap_clear_not_write: assert property (@(posedge clk) disable iff (!arst_n)
		clr_en |-> state_q == S_SCAN && !wr_en)
		else $error("entry cleared outside a discover scan");

endmodule

// ----- verif/dhcp_lease_table_tb.sv -----
// self-checking testbench of the dhcp lease table: directed and random messages, scoreboard
`timescale 1ns / 100ps

module dhcp_lease_table_tb;
	import dlt_pkg::*;

	localparam int LEASES          = LEASE_COUNT_DEF;
	localparam int STALL_LIMIT     = 3000;
	localparam int HOLD_CYCLES     = 400;
	localparam int HOLD_AFTER      = 400;
	localparam int PHASES          = 5;
	localparam int ITEMS_PER_PHASE = 286;
	localparam int CLIENTS         = 12;

	// message kinds the block answers with a drop
	localparam logic [CMD_W-1:0] CMD_OTHER = 2'd2;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [MAC_W-1:0]  mac;
		logic              has_req;
		logic [IP_W-1:0]   ip;
		logic [TICK_W-1:0] now;
	} lease_msg_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IP_W-1:0]     ip;
	} lease_reply_t;

	class lease_scoreboard;
		logic [MAC_W-1:0]    owner[LEASES];
		logic [EXP_W-1:0]    expiry[LEASES];
		logic [PREFIX_W-1:0] prefix;
		logic [HOST_W-1:0]   base;
		lease_reply_t        replies[$];
		int                  errors;

		function new();
			prefix = PREFIX_RST;
			base = BASE_RST;
			errors = 0;
			foreach (owner[i]) begin
				owner[i] = '0;
				expiry[i] = '0;
			end
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == REG_SERVER_PREFIX)
				prefix = data[PREFIX_W-1:0];
			else
				base = data[HOST_W-1:0];
		endfunction

		function logic [IP_W-1:0] addr_of(int idx);
			logic [HOST_W-1:0] host;
			host = base + HOST_W'(idx);
			return {prefix, host};
		endfunction

		// update the table for one accepted message and queue the reply it causes
		function void note_msg(lease_msg_t m);
			lease_reply_t      r;
			int                i;
			int                pick;
			bit                found;
			logic [HOST_W-1:0] slot;
			logic [TICK_W-1:0] diff;
			logic [TICK_W-1:0] lease_end;
			r.status = ST_DROP;
			r.ip = '0;
			pick = 0;
			found = 1'b0;
			if (m.cmd == CMD_DISCOVER) begin
				for (i = 0; i < LEASES; i++) begin
					if (owner[i] == m.mac) begin
						pick = i;
						found = 1'b1;
						break;
					end
					// free / lapsed test only until a candidate is known
					if (!found) begin
						if (owner[i] == '0) begin
							pick = i;
							found = 1'b1;
						end
						diff = {expiry[i], LOW_FILL} - m.now;
						if (diff[TICK_W-1]) begin
							owner[i] = '0;
							pick = i;
							found = 1'b1;
						end
					end
				end
				if (found) begin
					r.status = ST_OFFER;
					r.ip = addr_of(pick);
				end
			end else if (m.cmd == CMD_REQUEST) begin
				slot = m.ip[HOST_W-1:0] - base;
				if (m.has_req && m.ip[IP_W-1:HOST_W] == prefix && slot < LEASES
						&& (owner[slot] == m.mac || owner[slot] == '0)) begin
					owner[slot] = m.mac;
					lease_end = m.now + LEASE_MS;
					expiry[slot] = lease_end[TICK_W-1:TICK_W-EXP_W];
					r.status = ST_ACK;
					r.ip = addr_of(slot);
				end
			end
			replies.push_back(r);
		endfunction

		function void check_reply(logic [STATUS_W-1:0] status, logic [IP_W-1:0] ip);
			lease_reply_t want;
			if (replies.size() == 0) begin
				$error("reply with none pending: status %0d, assigned_ip %h", status, ip);
				errors++;
				return;
			end
			want = replies.pop_front();
			if (status !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, status);
				errors++;
			end
			if (ip !== want.ip) begin
				$error("assigned_ip: expected %h, actual %h", want.ip, ip);
				errors++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	dlt_req_if req();
	dlt_res_if res();

	lease_scoreboard  sb = new();
	logic [MAC_W-1:0] clients[CLIENTS];
	logic [TICK_W-1:0] clock_ms;
	bit               calm;
	int               sent;
	int               idle_cycles;

	dhcp_lease_table #(.LEASE_COUNT(LEASES)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	function automatic lease_msg_t make_msg(logic [CMD_W-1:0] cmd, logic [MAC_W-1:0] mac,
			logic has_req, logic [IP_W-1:0] ip, logic [TICK_W-1:0] now);
		lease_msg_t m;
		m.cmd = cmd;
		m.mac = mac;
		m.has_req = has_req;
		m.ip = ip;
		m.now = now;
		return m;
	endfunction

	// mostly well-formed traffic from a small client pool, time moving so leases lapse
	function automatic lease_msg_t random_msg();
		lease_msg_t m;
		int         roll;
		roll = $urandom_range(99);
		if (roll < 70)
			clock_ms += $urandom_range(2_000_000);
		else if (roll < 92)
			clock_ms += $urandom_range(100_000_000, 20_000_000);
		else
			clock_ms = $urandom;
		m.now = clock_ms;
		roll = $urandom_range(99);
		if (roll < 3)
			m.mac = '0;
		else if (roll < 6)
			m.mac = MAC_W'({$urandom, $urandom});
		else
			m.mac = clients[$urandom_range(CLIENTS - 1)];
		m.has_req = ($urandom_range(99) < 95);
		roll = $urandom_range(99);
		if (roll < 45)
			m.cmd = CMD_DISCOVER;
		else if (roll < 90)
			m.cmd = CMD_REQUEST;
		else if (roll < 95)
			m.cmd = CMD_OTHER;
		else
			m.cmd = CMD_SPARE;
		roll = $urandom_range(99);
		if (roll < 85)
			m.ip = sb.addr_of($urandom_range(LEASES + 1));
		else if (roll < 95)
			m.ip = {sb.prefix, HOST_W'($urandom)};
		else
			m.ip = $urandom;
		return m;
	endfunction

	task automatic send_msg(lease_msg_t m);
		while (!calm && $urandom_range(99) < 26) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= m.cmd;
		req.client_mac <= m.mac;
		req.req_present <= m.has_req;
		req.requested_ip <= m.ip;
		req.now_ms <= m.now;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.note_msg(m);
		sent++;
	endtask

	task automatic write_regs(logic [PREFIX_W-1:0] prefix, logic [HOST_W-1:0] base);
		cfg_we <= 1'b1;
		cfg_idx <= REG_SERVER_PREFIX;
		cfg_wdata <= prefix;
		@(posedge clk);
		sb.set_reg(REG_SERVER_PREFIX, prefix);
		cfg_idx <= REG_BASE_HOST;
		cfg_wdata <= CFG_W'(base);
		@(posedge clk);
		sb.set_reg(REG_BASE_HOST, CFG_W'(base));
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (sb.replies.size() != 0)
			@(posedge clk);
		repeat (LEASES + 8) @(posedge clk);
	endtask

	initial begin
		lease_msg_t          plan[$];
		logic [PREFIX_W-1:0] prefixes[PHASES-1];
		logic [HOST_W-1:0]   bases[PHASES-1];
		int                  i;
		int                  p;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_SERVER_PREFIX;
		cfg_wdata <= '0;
		req.valid <= 1'b0;
		req.cmd <= CMD_DISCOVER;
		req.client_mac <= '0;
		req.req_present <= 1'b0;
		req.requested_ip <= '0;
		req.now_ms <= '0;
		calm = 1'b0;
		sent = 0;
		clock_ms = '0;
		foreach (clients[k])
			clients[k] = MAC_W'({$urandom, $urandom});
		prefixes = '{24'hFFFFFF, 24'h000000, PREFIX_W'($urandom), PREFIX_RST};
		bases = '{8'hFF, 8'h00, HOST_W'($urandom), 8'hF8};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan.push_back(make_msg(CMD_DISCOVER, clients[0], 1'b0, '0, '0));
		// a zero mac matches the first free entry
		plan.push_back(make_msg(CMD_DISCOVER, '0, 1'b1, '1, '0));
		plan.push_back(make_msg(CMD_REQUEST, clients[0], 1'b1, sb.addr_of(0), '0));
		plan.push_back(make_msg(CMD_DISCOVER, clients[0], 1'b0, '0, 32'd5));
		plan.push_back(make_msg(CMD_DISCOVER, '0, 1'b0, '0, 32'd5));
		// request rejects: other owner, no option, prefix, index range both ways
		plan.push_back(make_msg(CMD_REQUEST, clients[1], 1'b1, sb.addr_of(0), 32'd10));
		plan.push_back(make_msg(CMD_REQUEST, clients[1], 1'b0, sb.addr_of(1), 32'd10));
		plan.push_back(make_msg(CMD_REQUEST, clients[1], 1'b1,
			sb.addr_of(1) ^ 32'h0100_0000, 32'd10));
		plan.push_back(make_msg(CMD_REQUEST, clients[1], 1'b1, sb.addr_of(LEASES), 32'd10));
		plan.push_back(make_msg(CMD_REQUEST, clients[1], 1'b1, sb.addr_of(-1), 32'd10));
		plan.push_back(make_msg(CMD_OTHER, clients[0], 1'b1, sb.addr_of(1), 32'd10));
		plan.push_back(make_msg(CMD_SPARE, clients[1], 1'b1, sb.addr_of(1), 32'd10));
		for (i = 1; i < LEASES; i++)
			plan.push_back(make_msg(CMD_REQUEST, (i == LEASES - 1) ? {MAC_W{1'b1}} : clients[i],
				1'b1, sb.addr_of(i), 32'd1000));
		// full table, then every lease lapsed, then an expiry that wraps
		plan.push_back(make_msg(CMD_DISCOVER, clients[10], 1'b0, '0, 32'd2000));
		plan.push_back(make_msg(CMD_DISCOVER, clients[10], 1'b0, '0, 32'h0600_0000));
		plan.push_back(make_msg(CMD_REQUEST, clients[10], 1'b1, sb.addr_of(0), 32'hFFFF_F000));
		plan.push_back(make_msg(CMD_DISCOVER, clients[11], 1'b1, '1, '1));
		plan.push_back(make_msg(CMD_REQUEST, clients[0], 1'b1, '1, '1));
		foreach (plan[k])
			send_msg(plan[k]);

		clock_ms = 32'h0700_0000;
		for (p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				drain();
				write_regs(prefixes[p-1], bases[p-1]);
			end
			calm = (p == 2);
			repeat (ITEMS_PER_PHASE) send_msg(random_msg());
		end
		drain();
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// reply side: random stalls, one long hold-off while the sender keeps offering
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res.valid && res.ready)
				sb.check_reply(res.status, res.assigned_ip);
			if (!held && sent >= HOLD_AFTER) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				res.ready <= 1'b0;
				hold_left--;
			end else
				res.ready <= calm || ($urandom_range(99) >= 26);
		end
	end

	// no transfer on either side for too long means the block hung
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (res.valid && res.ready))
			idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule
